>>> rtl/imhq_pkg.sv
`default_nettype none
package imhq_pkg;

   localparam int ID_BITS    = 16;
   localparam int HEAP_DEPTH = 2048;
   localparam int POS_BITS   = $clog2(HEAP_DEPTH);
   localparam int VAL_BITS   = 31;
   localparam int ID_SLOTS   = 1 << ID_BITS;

   localparam logic [POS_BITS-1:0] MAX_COUNT = POS_BITS'(HEAP_DEPTH - 1);
   localparam logic [VAL_BITS:0]   VAL_MAX   = {1'b0, {VAL_BITS{1'b1}}};
   localparam logic [VAL_BITS:0]   COST_RAISE = (VAL_BITS + 1)'(10);

   // command codes
   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_POP    = 3'd1;
   localparam logic [2:0] CMD_CANCEL = 3'd2;
   localparam logic [2:0] CMD_UPDATE = 3'd3;
   localparam logic [2:0] CMD_LOOKUP = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_REMOVED   = 3'd5;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [VAL_BITS-1:0] cost;
      logic [VAL_BITS-1:0] duration;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // strict heap order: cost first, then duration
   function automatic logic entry_less(input entry_type a, input entry_type b);
      logic r;
      if (a.cost != b.cost) r = (a.cost < b.cost);
      else                  r = (a.duration < b.duration);
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/imhq_ram.sv
`default_nettype none
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> rtl/indexed_min_heap_queue_core.sv
`default_nettype none
// Indexed min-heap priority queue of (id, cost, duration) entries.
// Command channel: a transaction is taken at a clock edge where start is high
// and busy is low; req_cmd selects insert, take-next, cancel, update duration
// or lookup. Exactly one response per command appears on the rsp_ ports for a
// single cycle with rsp_valid high; the receiver cannot stall it, and busy
// stays high until that response cycle, so commands never overlap.
// A duplicate, full, empty, not-found or unused command is answered from the
// slot stage alone; a lookup or a removal of the last entry also reads the
// target heap slot; other inserts, updates and removals sift up or down.
// The single read port of the heap memory sets the pace of a sift: every
// level of a sift needs a memory read, a compare and a write-back.
// Storage: heap memory of HEAP_DEPTH entries and an id-to-slot memory of
// 2^ID_BITS entries. After reset the block runs a clearing pass over the
// id-to-slot memory, with busy high, before the first command is taken.
// Reset also empties the heap.
module indexed_min_heap_queue_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [2:0]                   req_cmd,
   input  wire  [imhq_pkg::ID_BITS-1:0] req_ride_id,
   input  wire  [30:0]                  req_cost,
   input  wire  [30:0]                  req_duration,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic [imhq_pkg::ID_BITS-1:0] rsp_out_id,
   output logic [30:0]                  rsp_out_cost,
   output logic [30:0]                  rsp_out_duration
);
   import imhq_pkg::*;

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b000000000001,
      S_IDLE   = 12'b000000000010,
      S_SLOT   = 12'b000000000100,
      S_RDTGT  = 12'b000000001000,
      S_RDLAST = 12'b000000010000,
      S_UP     = 12'b000000100000,
      S_UPCMP  = 12'b000001000000,
      S_DOWN   = 12'b000010000000,
      S_DNL    = 12'b000100000000,
      S_DNR    = 12'b001000000000,
      S_DNCMP  = 12'b010000000000,
      S_FINAL  = 12'b100000000000
   } state_type;

   typedef enum logic [1:0] {
      ORD_UP   = 2'd0,
      ORD_DN   = 2'd1,
      ORD_UPDN = 2'd2,
      ORD_DNUP = 2'd3
   } order_type;

   state_type state_ff, state_in;
   order_type order_ff, order_in;
   logic [ID_BITS-1:0]  clr_ff, clr_in;
   logic [POS_BITS-1:0] count_ff, count_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] tgt_ff, tgt_in;
   logic [POS_BITS-1:0] chpos_ff, chpos_in;
   logic [2:0]          cmd_ff, cmd_in;
   entry_type           req_ff, req_in;
   entry_type           cur_ff, cur_in;
   entry_type           left_ff, left_in;
   entry_type           ch_ff, ch_in;
   logic                vld_ff, vld_in;
   logic [2:0]          st_ff, st_in;
   entry_type           out_ff, out_in;

   // memory ports
   logic                heap_we;
   logic [POS_BITS-1:0] heap_waddr, heap_raddr;
   entry_type           heap_wdata, heap_rdata;
   logic [ENTRY_BITS-1:0] heap_rbits;
   logic                slot_we;
   logic [ID_BITS-1:0]  slot_waddr, slot_raddr;
   logic [POS_BITS-1:0] slot_wdata, slot_rdata;

   logic [POS_BITS-1:0] par_pos;
   logic [POS_BITS:0]   lchild, rchild;
   logic [POS_BITS-1:0] found;
   logic [VAL_BITS:0]   raised;

   assign heap_rdata = entry_type'(heap_rbits);
   assign par_pos = pos_ff >> 1;
   assign lchild  = {pos_ff, 1'b0};
   assign rchild  = {pos_ff, 1'b1};
   assign found   = (slot_rdata != '0 && slot_rdata <= count_ff) ? slot_rdata : '0;
   assign raised  = {1'b0, heap_rdata.cost} + COST_RAISE;

   imhq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(HEAP_DEPTH)) u_heap_ram (
      .clock (clock),
      .we    (heap_we),
      .waddr (heap_waddr),
      .wdata (heap_wdata),
      .raddr (heap_raddr),
      .rdata (heap_rbits)
   );

   imhq_ram #(.WIDTH(POS_BITS), .DEPTH(ID_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      order_in = order_ff;
      clr_in   = clr_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      tgt_in   = tgt_ff;
      chpos_in = chpos_ff;
      cmd_in   = cmd_ff;
      req_in   = req_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      ch_in    = ch_ff;
      vld_in   = 1'b0;
      st_in    = st_ff;
      out_in   = out_ff;

      heap_we    = 1'b0;
      heap_waddr = pos_ff;
      heap_wdata = cur_ff;
      heap_raddr = par_pos;
      slot_we    = 1'b0;
      slot_waddr = cur_ff.id;
      slot_wdata = pos_ff;
      slot_raddr = req_ride_id;

      unique case (state_ff)
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == {ID_BITS{1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd_in         = req_cmd;
               req_in.id      = req_ride_id;
               req_in.cost    = req_cost;
               req_in.duration = req_duration;
               state_in       = S_SLOT;
            end
         end
         S_SLOT: begin
            st_in  = ST_OK;
            out_in = '0;
            tgt_in = (cmd_ff == CMD_POP) ? POS_BITS'(1) : found;
            heap_raddr = (cmd_ff == CMD_POP) ? POS_BITS'(1) : found;
            priority if (cmd_ff == CMD_INSERT) begin
               if (found != '0) begin
                  st_in = ST_DUPLICATE; vld_in = 1'b1; state_in = S_IDLE;
               end else if (count_ff == MAX_COUNT) begin
                  st_in = ST_FULL; vld_in = 1'b1; state_in = S_IDLE;
               end else begin
                  count_in = count_ff + 1'b1;
                  pos_in   = count_ff + 1'b1;
                  cur_in   = req_ff;
                  order_in = ORD_UP;
                  state_in = S_UP;
               end
            end else if (cmd_ff == CMD_POP) begin
               if (count_ff == '0) begin
                  st_in = ST_EMPTY; vld_in = 1'b1; state_in = S_IDLE;
               end else begin
                  state_in = S_RDTGT;
               end
            end else if (cmd_ff == CMD_CANCEL || cmd_ff == CMD_UPDATE ||
                         cmd_ff == CMD_LOOKUP) begin
               if (found == '0) begin
                  st_in = ST_NOT_FOUND; vld_in = 1'b1; state_in = S_IDLE;
               end else begin
                  state_in = S_RDTGT;
               end
            end else begin
               vld_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_RDTGT: begin
            // heap_rdata holds the addressed entry
            heap_raddr = count_ff;
            if (cmd_ff == CMD_LOOKUP) begin
               out_in = heap_rdata; vld_in = 1'b1; state_in = S_IDLE;
            end else if (cmd_ff == CMD_UPDATE &&
                         {1'b0, req_ff.duration} <= {heap_rdata.duration, 1'b0}) begin
               cur_in = heap_rdata;
               if (req_ff.duration > heap_rdata.duration)
                  cur_in.cost = (raised > VAL_MAX) ? VAL_MAX[VAL_BITS-1:0]
                                                   : raised[VAL_BITS-1:0];
               cur_in.duration = req_ff.duration;
               pos_in   = tgt_ff;
               order_in = ORD_UPDN;
               state_in = S_UP;
            end else begin
               // removal of the entry at tgt
               if (cmd_ff == CMD_POP) out_in = heap_rdata;
               if (cmd_ff == CMD_UPDATE) st_in = ST_REMOVED;
               slot_we    = 1'b1;
               slot_waddr = heap_rdata.id;
               slot_wdata = '0;
               count_in   = count_ff - 1'b1;
               if (tgt_ff == count_ff) begin
                  vld_in = 1'b1; state_in = S_IDLE;
               end else begin
                  state_in = S_RDLAST;
               end
            end
         end
         S_RDLAST: begin
            cur_in   = heap_rdata;
            pos_in   = tgt_ff;
            order_in = ORD_DNUP;
            state_in = S_DOWN;
         end
         S_UP: begin
            heap_raddr = par_pos;
            if (pos_ff == POS_BITS'(1)) begin
               if (order_ff == ORD_UPDN) begin
                  order_in = ORD_DN; state_in = S_DOWN;
               end else begin
                  state_in = S_FINAL;
               end
            end else begin
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if (entry_less(cur_ff, heap_rdata)) begin
               // parent moves down into the hole
               heap_we    = 1'b1;
               heap_waddr = pos_ff;
               heap_wdata = heap_rdata;
               slot_we    = 1'b1;
               slot_waddr = heap_rdata.id;
               slot_wdata = pos_ff;
               pos_in     = par_pos;
               state_in   = S_UP;
            end else if (order_ff == ORD_UPDN) begin
               order_in = ORD_DN; state_in = S_DOWN;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_DOWN: begin
            heap_raddr = lchild[POS_BITS-1:0];
            if (lchild > {1'b0, count_ff}) begin
               if (order_ff == ORD_DNUP) begin
                  order_in = ORD_UP; state_in = S_UP;
               end else begin
                  state_in = S_FINAL;
               end
            end else begin
               state_in = S_DNL;
            end
         end
         S_DNL: begin
            heap_raddr = rchild[POS_BITS-1:0];
            left_in    = heap_rdata;
            ch_in      = heap_rdata;
            chpos_in   = lchild[POS_BITS-1:0];
            if (rchild <= {1'b0, count_ff}) state_in = S_DNR;
            else                            state_in = S_DNCMP;
         end
         S_DNR: begin
            if (entry_less(heap_rdata, left_ff)) begin
               ch_in    = heap_rdata;
               chpos_in = rchild[POS_BITS-1:0];
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (entry_less(cur_ff, ch_ff)) begin
               if (order_ff == ORD_DNUP) begin
                  order_in = ORD_UP; state_in = S_UP;
               end else begin
                  state_in = S_FINAL;
               end
            end else begin
               // smaller child moves up into the hole
               heap_we    = 1'b1;
               heap_waddr = pos_ff;
               heap_wdata = ch_ff;
               slot_we    = 1'b1;
               slot_waddr = ch_ff.id;
               slot_wdata = pos_ff;
               pos_in     = chpos_ff;
               state_in   = S_DOWN;
            end
         end
         S_FINAL: begin
            heap_we  = 1'b1;
            slot_we  = 1'b1;
            vld_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         order_ff <= ORD_UP;
         clr_ff   <= '0;
         count_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      tgt_ff   <= tgt_in;
      chpos_ff <= chpos_in;
      cmd_ff   <= cmd_in;
      req_ff   <= req_in;
      cur_ff   <= cur_in;
      left_ff  <= left_in;
      ch_ff    <= ch_in;
      st_ff    <= st_in;
      out_ff   <= out_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = vld_ff;
   assign rsp_status       = st_ff;
   assign rsp_out_id       = out_ff.id;
   assign rsp_out_cost     = out_ff.cost;
   assign rsp_out_duration = out_ff.duration;

endmodule
`default_nettype wire
